// ===== rtl/sip_pkg.sv =====
// ----------------------------------------------------------------------------
// sip_pkg
// Widths and the queue entry type shared by the segment intersection block.
// ----------------------------------------------------------------------------
package sip_pkg;

    localparam int COORD_BITS  = 16;
    localparam int DIFF_BITS   = COORD_BITS + 1;          // coordinate difference
    localparam int PROD_BITS   = 2 * DIFF_BITS;           // product of two differences
    localparam int SUM_BITS    = PROD_BITS + 1;           // line-equation value
    localparam int MAG_BITS    = 2 * COORD_BITS + 2;      // |s1|, |den|
    localparam int QUOT_BITS   = DIFF_BITS;               // quotient bits, one per step
    localparam int NUM_BITS    = MAG_BITS + QUOT_BITS;    // |s1| * |delta|
    localparam int QUEUE_DEPTH = 4;                       // power of two
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // classified pair, front to back
    typedef struct packed {
        logic                         hit;
        logic signed [SUM_BITS-1:0]   s1;
        logic signed [SUM_BITS:0]     den;
        logic signed [DIFF_BITS-1:0]  dxa;
        logic signed [DIFF_BITS-1:0]  dya;
        logic signed [COORD_BITS-1:0] ax0;
        logic signed [COORD_BITS-1:0] ay0;
    } t_job;

endpackage

// ===== rtl/sip_front.sv =====
// ----------------------------------------------------------------------------
// sip_front
// Accepts segment pairs, evaluates the four line equations and classifies
// each pair as crossing or not. Three register stages.
// ----------------------------------------------------------------------------
module sip_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [sip_pkg::COORD_BITS-1:0] i_a_start_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] i_a_start_y,
    input  logic signed [sip_pkg::COORD_BITS-1:0] i_a_end_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] i_a_end_y,
    input  logic signed [sip_pkg::COORD_BITS-1:0] i_b_start_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] i_b_start_y,
    input  logic signed [sip_pkg::COORD_BITS-1:0] i_b_end_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] i_b_end_y,
    output logic                                  o_job_valid,
    input  logic                                  i_job_ready,
    output sip_pkg::t_job                         o_job
);

    localparam int DB = sip_pkg::DIFF_BITS;
    localparam int PB = sip_pkg::PROD_BITS;
    localparam int SB = sip_pkg::SUM_BITS;
    localparam int CB = sip_pkg::COORD_BITS;

    logic en;

    // stage 1: differences
    logic                 r_d_valid;
    logic signed [DB-1:0] r_d_dxa, r_d_dya, r_d_dxb, r_d_dyb;
    logic signed [DB-1:0] r_d_ax0b, r_d_ay0b, r_d_ax1b, r_d_ay1b;
    logic signed [DB-1:0] r_d_bx0a, r_d_by0a, r_d_bx1a, r_d_by1a;
    logic signed [CB-1:0] r_d_ax0, r_d_ay0;

    // stage 2: products
    logic                 r_p_valid;
    logic signed [PB-1:0] r_p_s1a, r_p_s1b, r_p_s2a, r_p_s2b;
    logic signed [PB-1:0] r_p_t1a, r_p_t1b, r_p_t2a, r_p_t2b;
    logic signed [DB-1:0] r_p_dxa, r_p_dya;
    logic signed [CB-1:0] r_p_ax0, r_p_ay0;

    // stage 3: line-equation values
    logic                 r_s_valid;
    logic signed [SB-1:0] r_s_s1, r_s_s2, r_s_t1, r_s_t2;
    logic signed [DB-1:0] r_s_dxa, r_s_dya;
    logic signed [CB-1:0] r_s_ax0, r_s_ay0;

    logic s1_pos, s1_neg, s2_pos, s2_neg;
    logic t1_pos, t1_neg, t2_pos, t2_neg;

    assign en      = !(r_s_valid && !i_job_ready);
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= i_valid;
            r_p_valid <= r_d_valid;
            r_s_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_dxa  <= DB'(i_a_end_x)   - DB'(i_a_start_x);
            r_d_dya  <= DB'(i_a_end_y)   - DB'(i_a_start_y);
            r_d_dxb  <= DB'(i_b_end_x)   - DB'(i_b_start_x);
            r_d_dyb  <= DB'(i_b_end_y)   - DB'(i_b_start_y);
            r_d_ax0b <= DB'(i_a_start_x) - DB'(i_b_start_x);
            r_d_ay0b <= DB'(i_a_start_y) - DB'(i_b_start_y);
            r_d_ax1b <= DB'(i_a_end_x)   - DB'(i_b_start_x);
            r_d_ay1b <= DB'(i_a_end_y)   - DB'(i_b_start_y);
            r_d_bx0a <= DB'(i_b_start_x) - DB'(i_a_start_x);
            r_d_by0a <= DB'(i_b_start_y) - DB'(i_a_start_y);
            r_d_bx1a <= DB'(i_b_end_x)   - DB'(i_a_start_x);
            r_d_by1a <= DB'(i_b_end_y)   - DB'(i_a_start_y);
            r_d_ax0  <= i_a_start_x;
            r_d_ay0  <= i_a_start_y;

            r_p_s1a <= r_d_dyb * r_d_ax0b;
            r_p_s1b <= r_d_dxb * r_d_ay0b;
            r_p_s2a <= r_d_dyb * r_d_ax1b;
            r_p_s2b <= r_d_dxb * r_d_ay1b;
            r_p_t1a <= r_d_dya * r_d_bx0a;
            r_p_t1b <= r_d_dxa * r_d_by0a;
            r_p_t2a <= r_d_dya * r_d_bx1a;
            r_p_t2b <= r_d_dxa * r_d_by1a;
            r_p_dxa <= r_d_dxa;
            r_p_dya <= r_d_dya;
            r_p_ax0 <= r_d_ax0;
            r_p_ay0 <= r_d_ay0;

            r_s_s1  <= SB'(r_p_s1b) - SB'(r_p_s1a);
            r_s_s2  <= SB'(r_p_s2b) - SB'(r_p_s2a);
            r_s_t1  <= SB'(r_p_t1b) - SB'(r_p_t1a);
            r_s_t2  <= SB'(r_p_t2b) - SB'(r_p_t2a);
            r_s_dxa <= r_p_dxa;
            r_s_dya <= r_p_dya;
            r_s_ax0 <= r_p_ax0;
            r_s_ay0 <= r_p_ay0;
        end
    end

    // strict sign tests: a zero value never counts as a crossing
    always_comb begin
        s1_neg = r_s_s1[SB-1];
        s2_neg = r_s_s2[SB-1];
        t1_neg = r_s_t1[SB-1];
        t2_neg = r_s_t2[SB-1];
        s1_pos = !s1_neg && (r_s_s1 != '0);
        s2_pos = !s2_neg && (r_s_s2 != '0);
        t1_pos = !t1_neg && (r_s_t1 != '0);
        t2_pos = !t2_neg && (r_s_t2 != '0);

        o_job.hit = ((s1_pos && s2_neg) || (s1_neg && s2_pos)) &&
                    ((t1_pos && t2_neg) || (t1_neg && t2_pos));
        o_job.s1  = r_s_s1;
        o_job.den = (SB+1)'(r_s_s1) - (SB+1)'(r_s_s2);
        o_job.dxa = r_s_dxa;
        o_job.dya = r_s_dya;
        o_job.ax0 = r_s_ax0;
        o_job.ay0 = r_s_ay0;
    end

    assign o_job_valid = r_s_valid;

endmodule

// ===== rtl/sip_queue.sv =====
// ----------------------------------------------------------------------------
// sip_queue
// Short FIFO between the classifier and the divider pipeline.
// ----------------------------------------------------------------------------
module sip_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  sip_pkg::t_job i_push_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output sip_pkg::t_job o_pop_data
);

    localparam int PB = sip_pkg::QPTR_BITS;

    sip_pkg::t_job r_mem [sip_pkg::QUEUE_DEPTH];
    logic [PB-1:0] r_wr_ptr;
    logic [PB-1:0] r_rd_ptr;
    logic [PB:0]   r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != (PB+1)'(sip_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr_ptr] <= i_push_data;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PB+1)'(sip_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count missed a push");

endmodule

// ===== rtl/sip_back.sv =====
// ----------------------------------------------------------------------------
// sip_back
// Forms |s1|*|delta| / |den| for x and y with a pipelined restoring divider
// (one quotient bit per stage) and adds the offsets to the start point.
// ----------------------------------------------------------------------------
module sip_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_job_valid,
    output logic                                  o_job_ready,
    input  sip_pkg::t_job                         i_job,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_hit,
    output logic signed [sip_pkg::COORD_BITS-1:0] o_cross_x,
    output logic signed [sip_pkg::COORD_BITS-1:0] o_cross_y
);

    localparam int CB = sip_pkg::COORD_BITS;
    localparam int DB = sip_pkg::DIFF_BITS;
    localparam int SB = sip_pkg::SUM_BITS;
    localparam int MB = sip_pkg::MAG_BITS;
    localparam int QB = sip_pkg::QUOT_BITS;
    localparam int NB = sip_pkg::NUM_BITS;

    // one restoring division step: shift in the next numerator bit,
    // subtract the divisor if it fits, shift in the quotient bit
    function automatic logic [NB-1:0] div_step(input logic [NB-1:0] w,
                                               input logic [MB-1:0] d);
        logic [NB:0] sh;
        logic [MB:0] top;
        logic [MB:0] diff;
        sh   = {w, 1'b0};
        top  = sh[NB:QB];
        diff = top - {1'b0, d};
        if (top >= {1'b0, d}) begin
            div_step = {diff[MB-1:0], sh[QB-1:1], 1'b1};
        end else begin
            div_step = sh[NB-1:0];
        end
    endfunction

    logic en;
    logic pop;

    // magnitude stage
    logic                 r_a_valid;
    logic                 r_a_hit;
    logic [MB-1:0]        r_a_s1_mag, r_a_den_mag;
    logic [DB-1:0]        r_a_dx_mag, r_a_dy_mag;
    logic                 r_a_dx_neg, r_a_dy_neg;
    logic signed [CB-1:0] r_a_ax0, r_a_ay0;

    logic signed [SB-1:0] s1_abs;
    logic signed [SB:0]   den_abs;
    logic signed [DB-1:0] dx_abs, dy_abs;
    logic [NB-1:0]        prod_x, prod_y;

    // divider stages; index 0 holds the products
    logic                 r_dv_valid [QB+1];
    logic                 r_dv_hit   [QB+1];
    logic [MB-1:0]        r_dv_den   [QB+1];
    logic [NB-1:0]        r_dv_wx    [QB+1];
    logic [NB-1:0]        r_dv_wy    [QB+1];
    logic                 r_dv_nx    [QB+1];
    logic                 r_dv_ny    [QB+1];
    logic signed [CB-1:0] r_dv_ax0   [QB+1];
    logic signed [CB-1:0] r_dv_ay0   [QB+1];

    // output register
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic signed [CB-1:0] r_out_x, r_out_y;

    logic [QB-1:0]        q_x, q_y;
    logic signed [DB:0]   off_x, off_y;
    logic signed [DB:0]   px, py;

    assign en          = !r_out_valid || i_ready;
    assign o_job_ready = en;
    assign pop         = en && i_job_valid;

    always_comb begin
        s1_abs  = i_job.s1[SB-1]  ? -i_job.s1  : i_job.s1;
        den_abs = i_job.den[SB]   ? -i_job.den : i_job.den;
        dx_abs  = i_job.dxa[DB-1] ? -i_job.dxa : i_job.dxa;
        dy_abs  = i_job.dya[DB-1] ? -i_job.dya : i_job.dya;
        prod_x  = r_a_s1_mag * r_a_dx_mag;
        prod_y  = r_a_s1_mag * r_a_dy_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= QB; k++) r_dv_valid[k] <= 1'b0;
        end else if (en) begin
            r_a_valid     <= pop;
            r_dv_valid[0] <= r_a_valid;
            for (int k = 1; k <= QB; k++) r_dv_valid[k] <= r_dv_valid[k-1];
            r_out_valid   <= r_dv_valid[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_hit     <= i_job.hit;
            r_a_s1_mag  <= s1_abs[MB-1:0];
            r_a_den_mag <= den_abs[MB-1:0];
            r_a_dx_mag  <= dx_abs;
            r_a_dy_mag  <= dy_abs;
            r_a_dx_neg  <= i_job.dxa[DB-1];
            r_a_dy_neg  <= i_job.dya[DB-1];
            r_a_ax0     <= i_job.ax0;
            r_a_ay0     <= i_job.ay0;

            r_dv_hit[0] <= r_a_hit;
            r_dv_den[0] <= r_a_den_mag;
            r_dv_wx[0]  <= prod_x;
            r_dv_wy[0]  <= prod_y;
            r_dv_nx[0]  <= r_a_dx_neg;
            r_dv_ny[0]  <= r_a_dy_neg;
            r_dv_ax0[0] <= r_a_ax0;
            r_dv_ay0[0] <= r_a_ay0;

            for (int k = 1; k <= QB; k++) begin
                r_dv_hit[k] <= r_dv_hit[k-1];
                r_dv_den[k] <= r_dv_den[k-1];
                r_dv_wx[k]  <= div_step(r_dv_wx[k-1], r_dv_den[k-1]);
                r_dv_wy[k]  <= div_step(r_dv_wy[k-1], r_dv_den[k-1]);
                r_dv_nx[k]  <= r_dv_nx[k-1];
                r_dv_ny[k]  <= r_dv_ny[k-1];
                r_dv_ax0[k] <= r_dv_ax0[k-1];
                r_dv_ay0[k] <= r_dv_ay0[k-1];
            end

            r_out_hit <= r_dv_hit[QB];
            r_out_x   <= r_dv_hit[QB] ? px[CB-1:0] : '0;
            r_out_y   <= r_dv_hit[QB] ? py[CB-1:0] : '0;
        end
    end

    // quotient takes the sign of the segment delta
    always_comb begin
        q_x   = r_dv_wx[QB][QB-1:0];
        q_y   = r_dv_wy[QB][QB-1:0];
        off_x = r_dv_nx[QB] ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
        off_y = r_dv_ny[QB] ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
        px    = (DB+1)'(r_dv_ax0[QB]) + off_x;
        py    = (DB+1)'(r_dv_ay0[QB]) + off_y;
    end

    assign o_valid   = r_out_valid;
    assign o_hit     = r_out_hit;
    assign o_cross_x = r_out_x;
    assign o_cross_y = r_out_y;

    // a crossing pair always has |s1| < |s1 - s2|
    a_ratio_below_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_a_hit |-> r_a_den_mag > r_a_s1_mag)
        else $error("crossing pair with |s1| >= |den|");

    a_remainder_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_valid[QB] && r_dv_hit[QB] |->
            (r_dv_wx[QB][NB-1:QB] < r_dv_den[QB]) &&
            (r_dv_wy[QB][NB-1:QB] < r_dv_den[QB]))
        else $error("divider remainder not below divisor");

endmodule

// ===== rtl/segment_intersection_point.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_point
// Crossing point of two 2D segments: line-equation classifier, queue and
// pipelined divider.
// ----------------------------------------------------------------------------
// Throughput: one segment pair per cycle while the receiver keeps i_ready high;
// the divider retires one quotient bit per stage for x and y in parallel.
// Reset (synchronous, active low) clears all valid bits and the queue pointers
// and count; the data registers are not reset.
module segment_intersection_point (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [sip_pkg::COORD_BITS-1:0] i_a_start_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] i_a_start_y,
    input  logic signed [sip_pkg::COORD_BITS-1:0] i_a_end_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] i_a_end_y,
    input  logic signed [sip_pkg::COORD_BITS-1:0] i_b_start_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] i_b_start_y,
    input  logic signed [sip_pkg::COORD_BITS-1:0] i_b_end_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] i_b_end_y,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_hit,
    output logic signed [sip_pkg::COORD_BITS-1:0] o_cross_x,
    output logic signed [sip_pkg::COORD_BITS-1:0] o_cross_y
);

    logic          push_valid, push_ready;
    logic          pop_valid, pop_ready;
    sip_pkg::t_job push_job, pop_job;

    sip_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_a_start_x (i_a_start_x),
        .i_a_start_y (i_a_start_y),
        .i_a_end_x   (i_a_end_x),
        .i_a_end_y   (i_a_end_y),
        .i_b_start_x (i_b_start_x),
        .i_b_start_y (i_b_start_y),
        .i_b_end_x   (i_b_end_x),
        .i_b_end_y   (i_b_end_y),
        .o_job_valid (push_valid),
        .i_job_ready (push_ready),
        .o_job       (push_job)
    );

    sip_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_job)
    );

    sip_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (pop_valid),
        .o_job_ready (pop_ready),
        .i_job       (pop_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_hit       (o_hit),
        .o_cross_x   (o_cross_x),
        .o_cross_y   (o_cross_y)
    );

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks segment_intersection_point against an in-bench prediction of the
// crossing test and the truncated crossing point: directed corner cases,
// then random segment pairs under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module testbench;
    localparam int COORD_BITS     = sip_pkg::COORD_BITS;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int TAIL_CYCLES    = 40;    // above the pipeline latency
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with work pending and no transaction
    localparam int PHASE_PAIRS    = 375;

    typedef struct {
        logic signed [COORD_BITS-1:0] ax0, ay0, ax1, ay1;
        logic signed [COORD_BITS-1:0] bx0, by0, bx1, by1;
    } t_seg_pair;

    typedef struct {
        logic                         hit;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_crossing;

    typedef enum int {MIX_FULL, MIX_TINY, MIX_EDGE} t_coord_mix;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      i_valid   = 1'b0;
    logic      i_ready   = 1'b0;
    t_seg_pair drive_pair = '{default: '0};
    logic      o_ready;
    logic      o_valid;
    logic      o_hit;
    logic signed [COORD_BITS-1:0] o_cross_x;
    logic signed [COORD_BITS-1:0] o_cross_y;

    t_crossing crossing_q[$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;

    segment_intersection_point dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_a_start_x (drive_pair.ax0),
        .i_a_start_y (drive_pair.ay0),
        .i_a_end_x   (drive_pair.ax1),
        .i_a_end_y   (drive_pair.ay1),
        .i_b_start_x (drive_pair.bx0),
        .i_b_start_y (drive_pair.by0),
        .i_b_end_x   (drive_pair.bx1),
        .i_b_end_y   (drive_pair.by1),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_hit       (o_hit),
        .o_cross_x   (o_cross_x),
        .o_cross_y   (o_cross_y)
    );

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // trunc(s1*delta/den); s1/den lies in (0,1) so the signs of s1 and den agree
    function automatic longint scaled_offset(longint s1, longint den, longint delta);
        longint q;
        q = (magnitude(s1) * magnitude(delta)) / magnitude(den);
        return (delta < 0) ? -q : q;
    endfunction

    function automatic t_crossing predict_crossing(t_seg_pair p);
        longint    ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        longint    dxa, dya, dxb, dyb, s1, s2, t1, t2;
        logic      split_a, split_b;
        t_crossing r;
        ax0 = p.ax0;  ay0 = p.ay0;  ax1 = p.ax1;  ay1 = p.ay1;
        bx0 = p.bx0;  by0 = p.by0;  bx1 = p.bx1;  by1 = p.by1;
        dxa = ax1 - ax0;  dya = ay1 - ay0;
        dxb = bx1 - bx0;  dyb = by1 - by0;
        s1 = -dyb * (ax0 - bx0) + dxb * (ay0 - by0);
        s2 = -dyb * (ax1 - bx0) + dxb * (ay1 - by0);
        t1 = -dya * (bx0 - ax0) + dxa * (by0 - ay0);
        t2 = -dya * (bx1 - ax0) + dxa * (by1 - ay0);
        // strictly opposite signs; any zero means touching or degenerate
        split_a = (s1 > 0 && s2 < 0) || (s1 < 0 && s2 > 0);
        split_b = (t1 > 0 && t2 < 0) || (t1 < 0 && t2 > 0);
        r.hit = split_a && split_b;
        r.x   = '0;
        r.y   = '0;
        if (r.hit) begin
            r.x = COORD_BITS'(ax0 + scaled_offset(s1, s1 - s2, dxa));
            r.y = COORD_BITS'(ay0 + scaled_offset(s1, s1 - s2, dya));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // scoreboard, receiver and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_crossing want;
        logic      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                crossing_q.push_back(predict_crossing(drive_pair));
                moved = 1'b1;
            end
            if (o_valid && i_ready) begin
                moved = 1'b1;
                if (crossing_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got hit=%0b x=%0d y=%0d",
                             $time, o_hit, o_cross_x, o_cross_y);
                    mismatch_count++;
                end else begin
                    want = crossing_q.pop_front();
                    if (o_hit !== want.hit) begin
                        $display("%0t: hit mismatch: expected %0b, got %0b",
                                 $time, want.hit, o_hit);
                        mismatch_count++;
                    end
                    if (o_cross_x !== want.x) begin
                        $display("%0t: cross_x mismatch: expected %0d, got %0d",
                                 $time, want.x, o_cross_x);
                        mismatch_count++;
                    end
                    if (o_cross_y !== want.y) begin
                        $display("%0t: cross_y mismatch: expected %0d, got %0d",
                                 $time, want.y, o_cross_y);
                        mismatch_count++;
                    end
                end
            end
            if (!moved && (i_valid || crossing_q.size() != 0))
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d results outstanding",
                         $time, crossing_q.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_pair(input t_seg_pair p);
        @(negedge i_clk);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        drive_pair <= p;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // sender holds off until every outstanding transaction has returned
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (crossing_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_seg_pair make_pair(int ax0, int ay0, int ax1, int ay1,
                                            int bx0, int by0, int bx1, int by1);
        t_seg_pair p;
        p.ax0 = COORD_BITS'(ax0);  p.ay0 = COORD_BITS'(ay0);
        p.ax1 = COORD_BITS'(ax1);  p.ay1 = COORD_BITS'(ay1);
        p.bx0 = COORD_BITS'(bx0);  p.by0 = COORD_BITS'(by0);
        p.bx1 = COORD_BITS'(bx1);  p.by1 = COORD_BITS'(by1);
        return p;
    endfunction

    function automatic int rand_coord(t_coord_mix mix);
        int edges[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        case (mix)
            MIX_TINY: return int'($urandom_range(16)) - 8;
            MIX_EDGE: begin
                if ($urandom_range(1))
                    return edges[$urandom_range(6)];
                return int'($urandom_range(65535)) - 32768;
            end
            default:  return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic t_seg_pair rand_pair();
        int         pick, ax0, ay0, ax1, ay1, mx, my, ox, oy;
        t_coord_mix mix;
        pick = $urandom_range(99);
        if (pick < 25) begin
            // B straddles the midpoint of A, so most of these cross
            ax0 = int'($urandom_range(32767)) - 16384;
            ay0 = int'($urandom_range(32767)) - 16384;
            ax1 = int'($urandom_range(32767)) - 16384;
            ay1 = int'($urandom_range(32767)) - 16384;
            mx  = (ax0 + ax1) / 2;
            my  = (ay0 + ay1) / 2;
            ox  = int'($urandom_range(16382)) - 8191;
            oy  = int'($urandom_range(16382)) - 8191;
            return make_pair(ax0, ay0, ax1, ay1, mx + ox, my + oy, mx - ox, my - oy);
        end
        mix = (pick < 75) ? MIX_FULL : (pick < 90) ? MIX_TINY : MIX_EDGE;
        return make_pair(rand_coord(mix), rand_coord(mix), rand_coord(mix), rand_coord(mix),
                         rand_coord(mix), rand_coord(mix), rand_coord(mix), rand_coord(mix));
    endfunction

    task automatic run_random(input int pairs, input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (pairs) send_pair(rand_pair());
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_pair(make_pair(-100, -100, 100, 100, -100, 100, 100, -100));
        // full-range diagonals, both orientations, and a full-range near-axis cross
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(make_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
        send_pair(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
        send_pair(make_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
        // nearly parallel long segments
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, -32767, 32767, 32766));
        // negative directions exercise truncation toward zero
        send_pair(make_pair(0, 0, -3, -7, -3, 0, 0, -7));
        send_pair(make_pair(1, 1, -6, -4, -5, 2, 0, -3));
        // endpoint of B on A, endpoint of A on B
        send_pair(make_pair(0, 0, 10, 0, 5, 0, 5, 10));
        send_pair(make_pair(5, -10, 5, 0, 0, 0, 10, 0));
        // collinear overlapping, parallel, lines crossing beyond the segments
        send_pair(make_pair(0, 0, 10, 10, 5, 5, 15, 15));
        send_pair(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
        send_pair(make_pair(0, 0, 10, 10, 0, 10, 4, 6));
        // zero-length segments lying on the other line
        send_pair(make_pair(3, 3, 3, 3, 0, 6, 6, 0));
        send_pair(make_pair(0, 6, 6, 0, 3, 3, 3, 3));
        // all fields at one value
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
        drain_results();
    endtask

    task automatic test_free_flow();
        run_random(PHASE_PAIRS, 0, 0);
    endtask

    task automatic test_sender_gaps();
        run_random(PHASE_PAIRS, 51, 0);
    endtask

    task automatic test_receiver_stalls();
        run_random(PHASE_PAIRS, 0, 51);
    endtask

    task automatic test_both_idle();
        run_random(PHASE_PAIRS, 6, 6);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_free_flow();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();

        // any stray result in the tail is flagged by the scoreboard
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sip_pkg.sv
rtl/sip_front.sv
rtl/sip_queue.sv
rtl/sip_back.sv
rtl/segment_intersection_point.sv
dv/testbench.sv
